@@ hw/rtl/ert_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expiring route table package
// Shared constants, command codes and transaction types.
// ----------------------------------------------------------------------------
package ert_pkg;

    localparam int ENTRIES = 16;
    localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = 7;
    localparam int RANK_W = 6;
    localparam int ADDR_W = 16;
    localparam int TICK_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRE_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARE_TICKS = 2'd2;

    localparam logic [TICK_W-1:0] EXPIRE_RESET = 16'd600;
    localparam logic [TICK_W-1:0] SHARE_RESET = 16'd60;

    typedef enum logic [2:0] {
        CMD_TICK = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_LOOKUP = 3'd2,
        CMD_MARK_SHARED = 3'd3,
        CMD_NEXT_TO_SHARE = 3'd4,
        CMD_RESET_TIMERS = 3'd5,
        CMD_FLUSH = 3'd6,
        CMD_NONE = 3'd7
    } cmd_t;

    typedef struct packed {
        logic [2:0] command;
        logic [ADDR_W-1:0] dest_addr;
        logic [ADDR_W-1:0] hop_addr;
    } req_t;

    typedef struct packed {
        logic found;
        logic [ADDR_W-1:0] next_hop;
        logic [ADDR_W-1:0] share_addr;
        logic table_full;
        logic [CNT_W-1:0] route_count;
    } rsp_t;

    // One table entry as kept in memory.
    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] hop;
        logic [TICK_W-1:0] expire_left;
        logic [TICK_W-1:0] share_left;
        logic share_armed;
        logic [RANK_W-1:0] rank;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ hw/rtl/ert_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read per cycle, with an optional write to the same address; read data is registered.
// ----------------------------------------------------------------------------
module ert_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
    input  logic [WIDTH-1:0]                 wdata,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ hw/rtl/expiring_route_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expiring route table
// Route table with per-entry expiry and share countdowns, held in one RAM.
// ----------------------------------------------------------------------------
// Usage: commands arrive on the req channel (req_valid / req_stall) and one
// response transaction leaves on the rsp channel (rsp_valid / rsp_stall) for
// every command. Configuration registers are written through cfg_we,
// cfg_index and cfg_data while the block is idle.
// Each command walks the ENTRIES slots of the entry RAM one at a time over
// the single RAM port, each slot read in ST_READ and evaluated in ST_EVAL
// (a flush stops after the first slot). Tick and timer reset write slots back
// as they go; insert and mark-shared write the matched slot, or for insert a
// free slot, once the walk ends. Removal on tick closes up ranks with a second
// pass over the RAM per removed entry.
// A new command is taken only after the previous response has been accepted;
// a stalled response holds and blocks the next command.
// Reset empties the table (valid bits and count cleared) and loads the
// register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module expiring_route_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  ert_pkg::req_t               req,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output ert_pkg::rsp_t               rsp,
    input  logic                        cfg_we,
    input  logic [ert_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ert_pkg::CFG_W-1:0]   cfg_data
);
    import ert_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_EVAL  = 6'b000100,
        ST_CLOSE = 6'b001000,
        ST_CEVAL = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] own_reg, own_next;
    logic [TICK_W-1:0] exp_reg, exp_next, shr_reg, shr_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0] count_reg, count_next;
    req_t cmd_reg, cmd_next;
    logic [SLOT_W:0] idx_reg, idx_next;
    logic pass_reg, pass_next;
    logic hit_reg, hit_next, best_ok_reg, best_ok_next;
    logic full_reg, full_next;
    logic [SLOT_W-1:0] hit_slot_reg, hit_slot_next;
    logic [RANK_W-1:0] best_rank_reg, best_rank_next;
    logic [ADDR_W-1:0] best_dest_reg, best_dest_next;
    logic [ADDR_W-1:0] hop_reg, hop_next;
    logic [RANK_W-1:0] gone_rank_reg, gone_rank_next;
    logic [SLOT_W:0] resume_reg, resume_next;
    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg, rsp_next;

    logic ram_we;
    logic [SLOT_W-1:0] ram_addr, slot;
    entry_t ram_wdata, ram_rdata, e;
    logic last;

    ert_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign req_stall = (state_reg != ST_IDLE) || rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;
    assign slot = idx_reg[SLOT_W-1:0];
    assign last = (idx_reg == (SLOT_W + 1)'(ENTRIES - 1));

    always_comb
    begin
        logic free_found;
        logic [SLOT_W-1:0] free_slot;
        free_found = 1'b0;
        free_slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_slot = SLOT_W'(i);
            end
        end

        state_next = state_reg;
        own_next = own_reg;
        exp_next = exp_reg;
        shr_next = shr_reg;
        valid_next = valid_reg;
        count_next = count_reg;
        cmd_next = cmd_reg;
        idx_next = idx_reg;
        pass_next = pass_reg;
        hit_next = hit_reg;
        hit_slot_next = hit_slot_reg;
        best_ok_next = best_ok_reg;
        full_next = full_reg;
        best_rank_next = best_rank_reg;
        best_dest_next = best_dest_reg;
        hop_next = hop_reg;
        gone_rank_next = gone_rank_reg;
        resume_next = resume_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next = rsp_reg;
        ram_we = 1'b0;
        ram_addr = slot;
        e = ram_rdata;
        ram_wdata = ram_rdata;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_OWN_ADDRESS: own_next = cfg_data;
                CFG_EXPIRE_TICKS: exp_next = cfg_data;
                CFG_SHARE_TICKS: shr_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && !req_stall)
                begin
                    cmd_next = req;
                    idx_next = '0;
                    pass_next = 1'b0;
                    hit_next = 1'b0;
                    hit_slot_next = '0;
                    best_ok_next = 1'b0;
                    full_next = 1'b0;
                    best_rank_next = '0;
                    best_dest_next = '0;
                    hop_next = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                // Search pass: one slot per read.
                if (valid_reg[slot])
                begin
                    if (e.dest == cmd_reg.dest_addr && !hit_reg)
                    begin
                        hit_next = 1'b1;
                        hit_slot_next = slot;
                        hop_next = e.hop;
                    end
                    if (e.share_left == '0 && (!best_ok_reg || e.rank < best_rank_reg))
                    begin
                        best_ok_next = 1'b1;
                        best_rank_next = e.rank;
                        best_dest_next = e.dest;
                    end
                end
                state_next = ST_READ;
                idx_next = idx_reg + 1'b1;
                case (cmd_reg.command)
                    CMD_TICK:
                    begin
                        if (valid_reg[slot])
                        begin
                            ram_we = 1'b1;
                            if (e.share_left != '0)
                            begin
                                ram_wdata.share_left = e.share_left - 1'b1;
                            end
                            if (e.expire_left <= 16'd1)
                            begin
                                valid_next[slot] = 1'b0;
                                count_next = count_reg - 1'b1;
                                gone_rank_next = e.rank;
                                resume_next = idx_reg + 1'b1;
                                idx_next = '0;
                                state_next = ST_CLOSE;
                            end
                            else
                            begin
                                ram_wdata.expire_left = e.expire_left - 1'b1;
                            end
                        end
                        if (last && state_next != ST_CLOSE)
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    CMD_RESET_TIMERS:
                    begin
                        if (valid_reg[slot])
                        begin
                            ram_we = 1'b1;
                            ram_wdata.expire_left = exp_reg;
                            ram_wdata.share_left = e.share_armed ? shr_reg : '0;
                        end
                        if (last)
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    CMD_INSERT, CMD_MARK_SHARED:
                    begin
                        if (pass_reg)
                        begin
                            // Write-back of the matched slot.
                            ram_we = 1'b1;
                            if (cmd_reg.command == CMD_INSERT)
                            begin
                                ram_wdata.hop = cmd_reg.hop_addr;
                                ram_wdata.expire_left = exp_reg;
                            end
                            else
                            begin
                                ram_wdata.share_left = shr_reg;
                                ram_wdata.share_armed = 1'b1;
                            end
                            state_next = ST_DONE;
                        end
                        else if (last)
                        begin
                            if (hit_next)
                            begin
                                idx_next = {1'b0, hit_slot_next};
                                pass_next = 1'b1;
                                state_next = ST_READ;
                            end
                            else if (cmd_reg.command == CMD_INSERT && free_found)
                            begin
                                ram_we = 1'b1;
                                ram_addr = free_slot;
                                ram_wdata.dest = cmd_reg.dest_addr;
                                ram_wdata.hop = cmd_reg.hop_addr;
                                ram_wdata.expire_left = exp_reg;
                                ram_wdata.share_left = '0;
                                ram_wdata.share_armed = 1'b0;
                                ram_wdata.rank = RANK_W'(count_reg);
                                valid_next[free_slot] = 1'b1;
                                count_next = count_reg + 1'b1;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                full_next = (cmd_reg.command == CMD_INSERT);
                                state_next = ST_DONE;
                            end
                        end
                    end
                    CMD_FLUSH:
                    begin
                        valid_next = '0;
                        count_next = '0;
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        if (last)
                        begin
                            state_next = ST_DONE;
                        end
                    end
                endcase
            end
            ST_CLOSE:
            begin
                state_next = ST_CEVAL;
            end
            ST_CEVAL:
            begin
                // Close up ranks behind a removed entry.
                if (valid_reg[slot] && e.rank > gone_rank_reg)
                begin
                    ram_we = 1'b1;
                    ram_wdata.rank = e.rank - 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                state_next = ST_CLOSE;
                if (last)
                begin
                    if (resume_reg == (SLOT_W + 1)'(ENTRIES))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next = resume_reg;
                        state_next = ST_READ;
                    end
                end
            end
            ST_DONE:
            begin
                rsp_next = '0;
                rsp_next.route_count = count_reg;
                case (cmd_reg.command)
                    CMD_INSERT: rsp_next.table_full = full_reg;
                    CMD_LOOKUP:
                    begin
                        rsp_next.found = hit_reg;
                        rsp_next.next_hop = hit_reg ? hop_reg : '0;
                    end
                    CMD_MARK_SHARED: rsp_next.found = hit_reg;
                    CMD_NEXT_TO_SHARE:
                        rsp_next.share_addr = best_ok_reg ? best_dest_reg : own_reg;
                    default: ;
                endcase
                rsp_valid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            own_reg <= '0;
            exp_reg <= EXPIRE_RESET;
            shr_reg <= SHARE_RESET;
            valid_reg <= '0;
            count_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            own_reg <= own_next;
            exp_reg <= exp_next;
            shr_reg <= shr_next;
            valid_reg <= valid_next;
            count_reg <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        pass_reg <= pass_next;
        hit_reg <= hit_next;
        hit_slot_reg <= hit_slot_next;
        best_ok_reg <= best_ok_next;
        full_reg <= full_next;
        best_rank_reg <= best_rank_next;
        best_dest_reg <= best_dest_next;
        hop_reg <= hop_next;
        gone_rank_reg <= gone_rank_next;
        resume_reg <= resume_next;
        rsp_reg <= rsp_next;
    end

    // The count always matches the number of valid slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(valid_reg)))
        else $error("route count out of step with valid slots");

    // A response is only loaded from the done state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("response without finished command");

    // No command is taken while a response is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> req_stall)
        else $error("command accepted with response pending");

endmodule
